[design/i2cts_pkg.sv]
package i2cts_pkg;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        CMD_POLL      = 3'd0,
        CMD_START_WR  = 3'd1,
        CMD_START_RD  = 3'd2,
        CMD_BUF_WRITE = 3'd3,
        CMD_BUF_READ  = 3'd4
    } command_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_TX    = 3'd2,
        ACT_RCV   = 3'd3,
        ACT_ACK   = 3'd4,
        ACT_NACK  = 3'd5,
        ACT_STOP  = 3'd6,
        ACT_OFF   = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE       = 2'd0,
        ST_BUSY       = 2'd1,
        ST_WRONG_ADDR = 2'd2,
        ST_DEV_BUSY   = 2'd3
    } status_t;

    localparam logic CFG_DEV_A = 1'b0;
    localparam logic CFG_DEV_B = 1'b1;

    localparam logic [6:0] DEV_A_RESET = 7'd17;
    localparam logic [6:0] DEV_B_RESET = 7'd99;

    // memory port request: one access per transaction
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

endpackage

[design/i2cts_buf_ram.sv]
module i2cts_buf_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                clk,
    input  i2cts_pkg::mem_req_t req,
    output logic [7:0]          rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr[AW-1:0]] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata <= mem[req.addr[AW-1:0]];
        end
    end

endmodule

[design/i2c_transaction_sequencer.sv]
// Pipeline: each accepted transaction is registered in stage 1 (control
// update and buffer access), then in the output register.
// Throughput: one transaction per cycle unless out_ready stalls, set by the
// single buffer memory port, which every transaction uses at most once.
// Reset: rst_n clears the sequencer to idle and the device addresses to
// their defaults at once; the byte buffer holds no reset value.
module i2c_transaction_sequencer #(
    parameter int MAX_LEN = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] command,
    input  logic       tuner_select,
    input  logic [4:0] length,
    input  logic [3:0] index,
    input  logic [7:0] data_byte,
    input  logic       start_pending,
    input  logic       transfer_busy,
    input  logic       nack_seen,
    input  logic       receive_active,
    input  logic       ack_active,
    input  logic       stop_active,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] action,
    output logic [7:0] tx_byte,
    output logic [1:0] status,
    output logic [4:0] bytes_done,
    output logic       transfer_done,
    output logic [7:0] read_data
);

    // The buffer index is at most five bits wide (byte pointer range),
    // so only the first 32 entries can ever be reached.
    localparam int DEPTH = (MAX_LEN < 32) ? MAX_LEN : 32;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_START     = 8'b0000_0010,
        PH_ADDR      = 8'b0000_0100,
        PH_WRITE     = 8'b0000_1000,
        PH_READ      = 8'b0001_0000,
        PH_READ_ACK  = 8'b0010_0000,
        PH_READ_NACK = 8'b0100_0000,
        PH_STOP      = 8'b1000_0000
    } phase_t;

    // sequencer state
    phase_t     phase_reg, phase_next;
    logic       reading_reg, reading_next;
    logic [7:0] addr_byte_reg, addr_byte_next;
    logic [4:0] ptr_reg, ptr_next;
    logic [4:0] tlen_reg, tlen_next;
    logic [1:0] result_reg, result_next;
    logic [6:0] dev_a_reg, dev_b_reg;

    // stage 1: control result plus pending buffer read data
    logic       s1_valid_reg;
    logic [2:0] s1_act_reg;
    logic [7:0] s1_tx_reg;
    logic       s1_tx_mem_reg;
    logic       s1_rd_mem_reg;
    logic [1:0] s1_status_reg;
    logic [4:0] s1_count_reg;
    logic       s1_done_reg;

    // output register
    logic       out_valid_reg;
    logic [2:0] out_act_reg;
    logic [7:0] out_tx_reg;
    logic [1:0] out_status_reg;
    logic [4:0] out_count_reg;
    logic       out_done_reg;
    logic [7:0] out_rd_reg;

    logic       accept;
    logic       s1_advance;
    logic [2:0] act_c;
    logic [7:0] tx_c;
    logic       tx_mem_c;
    logic       rd_mem_c;
    logic [6:0] dev_c;
    logic       cmd_read_c;
    logic [7:0] rdata;

    i2cts_pkg::mem_req_t req;

    // Move stage 1 forward whenever the output register is free or drains.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;

    // Sequencer next state, engine action and buffer request.
    always_comb
    begin
        phase_next     = phase_reg;
        reading_next   = reading_reg;
        addr_byte_next = addr_byte_reg;
        ptr_next       = ptr_reg;
        tlen_next      = tlen_reg;
        result_next    = result_reg;
        act_c          = i2cts_pkg::ACT_NONE;
        tx_c           = 8'd0;
        tx_mem_c       = 1'b0;
        rd_mem_c       = 1'b0;
        req            = '0;
        dev_c          = tuner_select ? dev_b_reg : dev_a_reg;
        cmd_read_c     = (command == i2cts_pkg::CMD_START_RD);

        unique case (command)
            i2cts_pkg::CMD_POLL:
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (!start_pending)
                        begin
                            phase_next = PH_ADDR;
                            act_c      = i2cts_pkg::ACT_TX;
                            tx_c       = addr_byte_reg;
                        end
                    end
                    PH_ADDR:
                    begin
                        if (!transfer_busy)
                        begin
                            if (nack_seen)
                            begin
                                result_next = i2cts_pkg::ST_WRONG_ADDR;
                                phase_next  = PH_STOP;
                                act_c       = i2cts_pkg::ACT_STOP;
                            end
                            else if (ptr_reg >= tlen_reg)
                            begin
                                phase_next = PH_STOP;
                                act_c      = i2cts_pkg::ACT_STOP;
                            end
                            else if (!reading_reg)
                            begin
                                // fetch the first data byte from the buffer
                                phase_next = PH_WRITE;
                                act_c      = i2cts_pkg::ACT_TX;
                                tx_mem_c   = (32'(ptr_reg) < MAX_LEN);
                                req.rd_en  = tx_mem_c;
                                req.addr   = ptr_reg;
                            end
                            else
                            begin
                                phase_next = PH_READ;
                                act_c      = i2cts_pkg::ACT_RCV;
                            end
                        end
                    end
                    PH_WRITE:
                    begin
                        if (!transfer_busy)
                        begin
                            ptr_next = ptr_reg + 5'd1;
                            if (ptr_next >= tlen_reg)
                            begin
                                phase_next = PH_STOP;
                                act_c      = i2cts_pkg::ACT_STOP;
                            end
                            else
                            begin
                                act_c     = i2cts_pkg::ACT_TX;
                                tx_mem_c  = (32'(ptr_next) < MAX_LEN);
                                req.rd_en = tx_mem_c;
                                req.addr  = ptr_next;
                            end
                        end
                    end
                    PH_READ:
                    begin
                        if (!receive_active)
                        begin
                            // store the received byte at the current pointer
                            req.wr_en = (32'(ptr_reg) < MAX_LEN);
                            req.addr  = ptr_reg;
                            req.wdata = data_byte;
                            ptr_next  = ptr_reg + 5'd1;
                            if (ptr_next == 5'd1 && !data_byte[7])
                            begin
                                // device reports busy on its first byte
                                result_next = i2cts_pkg::ST_DEV_BUSY;
                                phase_next  = PH_READ_NACK;
                                act_c       = i2cts_pkg::ACT_NACK;
                            end
                            else if (ptr_next >= tlen_reg)
                            begin
                                phase_next = PH_READ_NACK;
                                act_c      = i2cts_pkg::ACT_NACK;
                            end
                            else
                            begin
                                phase_next = PH_READ_ACK;
                                act_c      = i2cts_pkg::ACT_ACK;
                            end
                        end
                    end
                    PH_READ_ACK:
                    begin
                        if (!ack_active)
                        begin
                            phase_next = PH_READ;
                            act_c      = i2cts_pkg::ACT_RCV;
                        end
                    end
                    PH_READ_NACK:
                    begin
                        if (!ack_active)
                        begin
                            phase_next = PH_STOP;
                            act_c      = i2cts_pkg::ACT_STOP;
                        end
                    end
                    PH_STOP:
                    begin
                        if (!stop_active)
                        begin
                            act_c      = i2cts_pkg::ACT_OFF;
                            phase_next = PH_IDLE;
                            if (result_reg == i2cts_pkg::ST_BUSY)
                            begin
                                result_next = i2cts_pkg::ST_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            i2cts_pkg::CMD_START_WR, i2cts_pkg::CMD_START_RD:
            begin
                // abandon any running transfer and begin a new one
                reading_next   = cmd_read_c;
                addr_byte_next = {dev_c, cmd_read_c};
                tlen_next      = (32'(length) > MAX_LEN) ? 5'(MAX_LEN) : length;
                ptr_next       = 5'd0;
                result_next    = i2cts_pkg::ST_BUSY;
                phase_next     = PH_START;
                act_c          = i2cts_pkg::ACT_START;
            end
            i2cts_pkg::CMD_BUF_WRITE:
            begin
                req.wr_en = (32'(index) < MAX_LEN);
                req.addr  = {1'b0, index};
                req.wdata = data_byte;
            end
            i2cts_pkg::CMD_BUF_READ:
            begin
                rd_mem_c  = (32'(index) < MAX_LEN);
                req.rd_en = rd_mem_c;
                req.addr  = {1'b0, index};
            end
            default:
            begin
            end
        endcase

        // touch the buffer only for an accepted transaction
        if (!accept)
        begin
            req = '0;
        end
    end

    i2cts_buf_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_buf_ram (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    // Configuration registers: to be written only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_a_reg <= i2cts_pkg::DEV_A_RESET;
            dev_b_reg <= i2cts_pkg::DEV_B_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == i2cts_pkg::CFG_DEV_A)
            begin
                dev_a_reg <= cfg_data;
            end
            if (cfg_index == i2cts_pkg::CFG_DEV_B)
            begin
                dev_b_reg <= cfg_data;
            end
        end
    end

    // Sequencer state: advance on each accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            reading_reg   <= 1'b0;
            addr_byte_reg <= 8'd0;
            ptr_reg       <= 5'd0;
            tlen_reg      <= 5'd0;
            result_reg    <= i2cts_pkg::ST_IDLE;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            reading_reg   <= reading_next;
            addr_byte_reg <= addr_byte_next;
            ptr_reg       <= ptr_next;
            tlen_reg      <= tlen_next;
            result_reg    <= result_next;
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept || (s1_valid_reg && !s1_advance);
            out_valid_reg <= s1_advance || (out_valid_reg && !out_ready);
        end
    end

    // Stage 1 payload: hold until it moves to the output register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_act_reg    <= act_c;
            s1_tx_reg     <= tx_c;
            s1_tx_mem_reg <= tx_mem_c;
            s1_rd_mem_reg <= rd_mem_c;
            s1_status_reg <= result_next;
            s1_count_reg  <= ptr_next;
            s1_done_reg   <= (phase_next == PH_IDLE);
        end
    end

    // Output register: merge buffer read data into the result.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_act_reg    <= s1_act_reg;
            out_tx_reg     <= s1_tx_mem_reg ? rdata : s1_tx_reg;
            out_status_reg <= s1_status_reg;
            out_count_reg  <= s1_count_reg;
            out_done_reg   <= s1_done_reg;
            out_rd_reg     <= s1_rd_mem_reg ? rdata : 8'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign action        = out_act_reg;
    assign tx_byte       = out_tx_reg;
    assign status        = out_status_reg;
    assign bytes_done    = out_count_reg;
    assign transfer_done = out_done_reg;
    assign read_data     = out_rd_reg;

endmodule

[design/i2cts_checker.sv]
module i2cts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] action,
    input logic [7:0] tx_byte,
    input logic [1:0] status,
    input logic [4:0] bytes_done,
    input logic       transfer_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(tx_byte)
            && $stable(status) && $stable(bytes_done))
        else $error("stalled result changed");

    // busy status never shows on an idle sequencer
    a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == i2cts_pkg::ST_BUSY |-> !transfer_done)
        else $error("busy status while idle");

    // a start opens a fresh transfer
    a_start_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == i2cts_pkg::ACT_START |->
            status == i2cts_pkg::ST_BUSY && bytes_done == 5'd0 && !transfer_done)
        else $error("start result inconsistent");

    // disable closes the transfer with a final status
    a_off_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == i2cts_pkg::ACT_OFF |->
            transfer_done && status != i2cts_pkg::ST_BUSY)
        else $error("disable without final status");

    // transmit byte is zero unless a byte is sent
    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != i2cts_pkg::ACT_TX |-> tx_byte == 8'd0)
        else $error("tx byte set without transmit");

endmodule

bind i2c_transaction_sequencer i2cts_checker u_i2cts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .tx_byte       (tx_byte),
    .status        (status),
    .bytes_done    (bytes_done),
    .transfer_done (transfer_done)
);

[bench/i2c_transaction_sequencer_test.sv]
`timescale 1ns / 100ps

localparam int BUF_DEPTH = 16;

typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_ADDR,
    SEQ_WRITE,
    SEQ_READ,
    SEQ_READ_ACK,
    SEQ_READ_NACK,
    SEQ_STOP
} seq_phase_t;

// one input transaction; engine flags are only looked at on a poll
typedef struct packed {
    logic [2:0] command;
    logic       tuner_select;
    logic [4:0] length;
    logic [3:0] index;
    logic [7:0] data_byte;
    logic       start_pending;
    logic       transfer_busy;
    logic       nack_seen;
    logic       receive_active;
    logic       ack_active;
    logic       stop_active;
} request_t;

typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic [4:0] bytes_done;
    logic       transfer_done;
    logic [7:0] read_data;
} step_result_t;

class transfer_scoreboard;
    logic [6:0]          dev_a;
    logic [6:0]          dev_b;
    seq_phase_t          phase;
    logic                rd_dir;
    logic [7:0]          addr_byte;
    logic [4:0]          ptr;
    logic [4:0]          xfer_len;
    i2cts_pkg::status_t  code;
    logic [7:0]          buffer [BUF_DEPTH];
    bit                  filled [BUF_DEPTH];
    step_result_t        expected_steps [$];
    int                  mismatches;

    function new();
        dev_a = i2cts_pkg::DEV_A_RESET;
        dev_b = i2cts_pkg::DEV_B_RESET;
        phase = SEQ_IDLE;
        rd_dir = 1'b0;
        addr_byte = '0;
        ptr = '0;
        xfer_len = '0;
        code = i2cts_pkg::ST_IDLE;
        mismatches = 0;
        foreach (filled[k])
        begin
            filled[k] = 1'b0;
            buffer[k] = '0;
        end
    endfunction

    function void set_register(logic idx, logic [6:0] val);
        if (idx == i2cts_pkg::CFG_DEV_A)
            dev_a = val;
        else
            dev_b = val;
    endfunction

    // true when every entry a write transfer of this length sends is known
    function bit buffer_ready(logic [4:0] len);
        int k;
        for (k = 0; k < BUF_DEPTH; k++)
            if (k < len && !filled[k])
                return 1'b0;
        return 1'b1;
    endfunction

    function void note_request(request_t rq);
        step_result_t o;
        logic [6:0]   dev;
        o = '0;
        o.action = i2cts_pkg::ACT_NONE;
        case (rq.command)
            i2cts_pkg::CMD_POLL:
            begin
                case (phase)
                    SEQ_START:
                        if (!rq.start_pending)
                        begin
                            phase = SEQ_ADDR;
                            o.action = i2cts_pkg::ACT_TX;
                            o.tx_byte = addr_byte;
                        end
                    SEQ_ADDR:
                        if (!rq.transfer_busy)
                        begin
                            if (rq.nack_seen)
                            begin
                                code = i2cts_pkg::ST_WRONG_ADDR;
                                phase = SEQ_STOP;
                                o.action = i2cts_pkg::ACT_STOP;
                            end
                            else if (ptr >= xfer_len)
                            begin
                                phase = SEQ_STOP;
                                o.action = i2cts_pkg::ACT_STOP;
                            end
                            else if (!rd_dir)
                            begin
                                phase = SEQ_WRITE;
                                o.action = i2cts_pkg::ACT_TX;
                                o.tx_byte = buffer[ptr[3:0]];
                            end
                            else
                            begin
                                phase = SEQ_READ;
                                o.action = i2cts_pkg::ACT_RCV;
                            end
                        end
                    SEQ_WRITE:
                        if (!rq.transfer_busy)
                        begin
                            ptr = ptr + 5'd1;
                            if (ptr >= xfer_len)
                            begin
                                phase = SEQ_STOP;
                                o.action = i2cts_pkg::ACT_STOP;
                            end
                            else
                            begin
                                o.action = i2cts_pkg::ACT_TX;
                                o.tx_byte = buffer[ptr[3:0]];
                            end
                        end
                    SEQ_READ:
                        if (!rq.receive_active)
                        begin
                            if (ptr < 5'(BUF_DEPTH))
                            begin
                                buffer[ptr[3:0]] = rq.data_byte;
                                filled[ptr[3:0]] = 1'b1;
                            end
                            ptr = ptr + 5'd1;
                            // first byte with bit 7 clear: device busy
                            if (ptr == 5'd1 && !rq.data_byte[7])
                            begin
                                code = i2cts_pkg::ST_DEV_BUSY;
                                phase = SEQ_READ_NACK;
                                o.action = i2cts_pkg::ACT_NACK;
                            end
                            else if (ptr >= xfer_len)
                            begin
                                phase = SEQ_READ_NACK;
                                o.action = i2cts_pkg::ACT_NACK;
                            end
                            else
                            begin
                                phase = SEQ_READ_ACK;
                                o.action = i2cts_pkg::ACT_ACK;
                            end
                        end
                    SEQ_READ_ACK:
                        if (!rq.ack_active)
                        begin
                            phase = SEQ_READ;
                            o.action = i2cts_pkg::ACT_RCV;
                        end
                    SEQ_READ_NACK:
                        if (!rq.ack_active)
                        begin
                            phase = SEQ_STOP;
                            o.action = i2cts_pkg::ACT_STOP;
                        end
                    SEQ_STOP:
                        if (!rq.stop_active)
                        begin
                            o.action = i2cts_pkg::ACT_OFF;
                            if (code == i2cts_pkg::ST_BUSY)
                                code = i2cts_pkg::ST_IDLE;
                            phase = SEQ_IDLE;
                        end
                    default:
                    begin
                    end
                endcase
            end
            i2cts_pkg::CMD_START_WR, i2cts_pkg::CMD_START_RD:
            begin
                dev = rq.tuner_select ? dev_b : dev_a;
                rd_dir = (rq.command == i2cts_pkg::CMD_START_RD);
                addr_byte = {dev, rd_dir};
                xfer_len = (rq.length > 5'(BUF_DEPTH)) ? 5'(BUF_DEPTH) : rq.length;
                ptr = '0;
                code = i2cts_pkg::ST_BUSY;
                phase = SEQ_START;
                o.action = i2cts_pkg::ACT_START;
            end
            i2cts_pkg::CMD_BUF_WRITE:
            begin
                buffer[rq.index] = rq.data_byte;
                filled[rq.index] = 1'b1;
            end
            i2cts_pkg::CMD_BUF_READ:
                o.read_data = buffer[rq.index];
            default:
            begin
            end
        endcase
        o.status = code;
        o.bytes_done = ptr;
        o.transfer_done = (phase == SEQ_IDLE);
        expected_steps.push_back(o);
    endfunction

    function void check_result(step_result_t got);
        step_result_t want;
        if (expected_steps.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: action %0d tx %02h status %0d done %0d",
                         got.action, got.tx_byte, got.status, got.bytes_done);
            return;
        end
        want = expected_steps.pop_front();
        if (got.action !== want.action || got.tx_byte !== want.tx_byte ||
            got.status !== want.status || got.bytes_done !== want.bytes_done ||
            got.transfer_done !== want.transfer_done || got.read_data !== want.read_data)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"bad result (exp/got): action %0d/%0d tx %02h/%02h status %0d/%0d",
                          " count %0d/%0d idle %0b/%0b read %02h/%02h"},
                         want.action, got.action, want.tx_byte, got.tx_byte,
                         want.status, got.status, want.bytes_done, got.bytes_done,
                         want.transfer_done, got.transfer_done,
                         want.read_data, got.read_data);
        end
    endfunction
endclass

module i2c_transaction_sequencer_test;

    // cycles without any accepted transaction before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // long hold-off of the result side, enough to back the block up
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 125;

    // command the block does not know
    localparam logic [2:0] CMD_RESERVED_HI = 3'd7;

    // engine flag masks: {start, busy, nack, receive, ack, stop}
    localparam logic [5:0] F_NONE  = 6'b000000;
    localparam logic [5:0] F_START = 6'b100000;
    localparam logic [5:0] F_NACK  = 6'b001000;
    localparam logic [5:0] F_STOP  = 6'b000001;
    localparam logic [5:0] F_ALL   = 6'b111111;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [6:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] command;
    logic       tuner_select;
    logic [4:0] length;
    logic [3:0] index;
    logic [7:0] data_byte;
    logic       start_pending;
    logic       transfer_busy;
    logic       nack_seen;
    logic       receive_active;
    logic       ack_active;
    logic       stop_active;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic [4:0] bytes_done;
    logic       transfer_done;
    logic [7:0] read_data;

    transfer_scoreboard sb;
    int items_sent = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;          // when set, neither side idles
    bit hold_request = 1'b0;  // ask the result side for one long hold-off

    i2c_transaction_sequencer u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic request_t make_req(logic [2:0] cmd, logic sel, logic [4:0] len,
                                          logic [3:0] idx, logic [7:0] data,
                                          logic [5:0] flags);
        request_t rq;
        rq.command = cmd;
        rq.tuner_select = sel;
        rq.length = len;
        rq.index = idx;
        rq.data_byte = data;
        {rq.start_pending, rq.transfer_busy, rq.nack_seen,
         rq.receive_active, rq.ack_active, rq.stop_active} = flags;
        return rq;
    endfunction

    function automatic request_t poll_req(logic [5:0] flags, logic [7:0] data);
        return make_req(i2cts_pkg::CMD_POLL, 1'b0, 5'd0, 4'd0, data, flags);
    endfunction

    function automatic request_t random_req();
        return make_req(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                        5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                        8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
    endfunction

    // Poll with flags that mostly let the sequencer advance; keep the awaited
    // flag set now and then, and bias received bytes toward bit 7 set so that
    // reads get past the first byte.
    function automatic request_t random_poll();
        request_t rq;
        rq = random_req();
        rq.command = i2cts_pkg::CMD_POLL;
        rq.start_pending = ($urandom_range(0, 3) == 0);
        rq.transfer_busy = ($urandom_range(0, 3) == 0);
        rq.nack_seen = ($urandom_range(0, 7) == 0);
        rq.receive_active = ($urandom_range(0, 3) == 0);
        rq.ack_active = ($urandom_range(0, 3) == 0);
        rq.stop_active = ($urandom_range(0, 3) == 0);
        rq.data_byte[7] = ($urandom_range(0, 3) != 0);
        return rq;
    endfunction

    // Offer one transaction after a random gap. Valid stays high from one
    // transaction to the next when there is no gap.
    task automatic send(request_t rq);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= rq.command;
        tuner_select <= rq.tuner_select;
        length <= rq.length;
        index <= rq.index;
        data_byte <= rq.data_byte;
        start_pending <= rq.start_pending;
        transfer_busy <= rq.transfer_busy;
        nack_seen <= rq.nack_seen;
        receive_active <= rq.receive_active;
        ack_active <= rq.ack_active;
        stop_active <= rq.stop_active;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(rq);
        if (rq.command <= i2cts_pkg::CMD_BUF_READ)
            items_sent++;
    endtask

    // Any random transaction, steered away from reads of buffer entries that
    // hold nothing yet, and from write transfers that would send such entries.
    task automatic send_noise();
        request_t rq;
        rq = random_req();
        if (rq.command == i2cts_pkg::CMD_BUF_READ)
        begin
            while (!sb.filled[rq.index])
                rq.index = rq.index + 4'd1;
        end
        if (rq.command == i2cts_pkg::CMD_START_WR && !sb.buffer_ready(rq.length))
            rq.command = i2cts_pkg::CMD_START_RD;
        send(rq);
    endtask

    // One complete bus transfer: fill what a write needs, start, then poll
    // until the sequencer is idle again. Now and then walk away mid-transfer
    // so that the next start abandons it.
    task automatic run_transfer();
        logic       rd;
        logic [4:0] len;
        int         k;
        int         polls;
        rd = 1'($urandom_range(0, 1));
        len = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 16));
        if (!rd)
        begin
            for (k = 0; k < BUF_DEPTH; k++)
                if (k < len && !sb.filled[k])
                    send(make_req(i2cts_pkg::CMD_BUF_WRITE, 1'b0, 5'd0, 4'(k),
                                  8'($urandom_range(0, 255)), 6'($urandom_range(0, 63))));
        end
        send(make_req(rd ? i2cts_pkg::CMD_START_RD : i2cts_pkg::CMD_START_WR,
                      1'($urandom_range(0, 1)), len,
                      4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      6'($urandom_range(0, 63))));
        polls = 0;
        while (sb.phase != SEQ_IDLE && polls < 150)
        begin
            if ($urandom_range(0, 39) == 0)
                break;
            send(random_poll());
            polls++;
        end
    endtask

    // Drop valid and wait until every expected result is back, plus the
    // pipeline depth, so the block is quiet.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_steps.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_register(idx, val);
    endtask

    // Result side: stall a random number of cycles after each transaction,
    // or one long stretch when asked.
    initial
    begin : result_sink
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            gap = calm ? 0 : $urandom_range(0, 3);
            if (hold_request)
            begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Check every result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({action, tx_byte, status, bytes_done, transfer_done, read_data});
    end

    // Hang detection: count cycles in which neither channel moves.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("i2c_transaction_sequencer: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int ph;
        int goal;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = i2cts_pkg::CMD_POLL;
        tuner_select = 1'b0;
        length = '0;
        index = '0;
        data_byte = '0;
        start_pending = 1'b0;
        transfer_busy = 1'b0;
        nack_seen = 1'b0;
        receive_active = 1'b0;
        ack_active = 1'b0;
        stop_active = 1'b0;
        sb = new();

        // hold reset, then release it once for the whole run
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the reset device addresses.
        // Buffer extremes: first and last entry, all-zero and all-one bytes.
        send(make_req(i2cts_pkg::CMD_BUF_WRITE, 1'b0, 5'd0, 4'd0, 8'h00, F_NONE));
        send(make_req(i2cts_pkg::CMD_BUF_WRITE, 1'b1, 5'd31, 4'd15, 8'hFF, F_ALL));
        send(make_req(i2cts_pkg::CMD_BUF_READ, 1'b0, 5'd0, 4'd15, 8'h00, F_NONE));
        send(make_req(i2cts_pkg::CMD_BUF_READ, 1'b1, 5'd31, 4'd0, 8'hFF, F_ALL));
        // unknown command and a poll while idle: no action
        send(make_req(CMD_RESERVED_HI, 1'b1, 5'd31, 4'd15, 8'hFF, F_ALL));
        send(poll_req(F_ALL, 8'hFF));
        // one-byte write to device a, with the start flag still set at first
        send(make_req(i2cts_pkg::CMD_START_WR, 1'b0, 5'd1, 4'd0, 8'h00, F_NONE));
        send(poll_req(F_START, 8'h00));
        send(poll_req(F_NONE, 8'h00));
        send(poll_req(F_NONE, 8'h00));
        send(poll_req(F_NONE, 8'h00));
        send(poll_req(F_STOP, 8'h00));
        send(poll_req(F_NONE, 8'h00));
        // oversize read from device b, address not acknowledged
        send(make_req(i2cts_pkg::CMD_START_RD, 1'b1, 5'd31, 4'd0, 8'h00, F_NONE));
        send(poll_req(F_NONE, 8'h00));
        send(poll_req(F_NACK, 8'h00));
        // abandon that stop with a new read: first byte says device busy
        send(make_req(i2cts_pkg::CMD_START_RD, 1'b0, 5'd2, 4'd0, 8'h00, F_NONE));
        send(poll_req(F_NONE, 8'h00));
        send(poll_req(F_NONE, 8'h00));
        send(poll_req(F_NONE, 8'h7F));
        send(poll_req(F_NONE, 8'h00));
        send(poll_req(F_NONE, 8'h00));
        // zero-length write: address, then straight to stop
        send(make_req(i2cts_pkg::CMD_START_WR, 1'b1, 5'd0, 4'd0, 8'h00, F_NONE));
        send(poll_req(F_NONE, 8'h00));
        send(poll_req(F_NONE, 8'h00));
        send(poll_req(F_NONE, 8'h00));

        // Random phases, each under its own device addresses. The sender
        // waits for every result before reprogramming the addresses.
        for (ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    write_reg(i2cts_pkg::CFG_DEV_A, 7'd0);
                    write_reg(i2cts_pkg::CFG_DEV_B, 7'd127);
                end
                1:
                begin
                    write_reg(i2cts_pkg::CFG_DEV_A, 7'd127);
                    write_reg(i2cts_pkg::CFG_DEV_B, 7'd0);
                end
                default:
                begin
                    write_reg(i2cts_pkg::CFG_DEV_A, 7'($urandom_range(0, 127)));
                    write_reg(i2cts_pkg::CFG_DEV_B, 7'($urandom_range(0, 127)));
                end
            endcase
            cfg_we <= 1'b0;
            // phase 1 runs back to back; phase 2 starts with a long stall
            calm = (ph == 1);
            if (ph == 2)
                hold_request = 1'b1;
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
            begin
                if ($urandom_range(0, 9) < 7)
                    run_transfer();
                else
                    repeat ($urandom_range(1, 4)) send_noise();
            end
        end

        // wait for the last results, then a few more cycles for strays
        drain();
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_steps.size() == 0)
            $display("i2c_transaction_sequencer: match");
        else
            $display("i2c_transaction_sequencer: mismatch");
        $finish;
    end

endmodule
